// ----- sv/tksel_pkg.sv -----
// tksel_pkg: shared types and constants for the top-k score selector
`default_nettype none

package tksel_pkg;

    // list depth and fixed field widths
    localparam int TOP_COUNT  = 5;
    localparam int INDEX_BITS = 16;
    localparam int SCORE_BITS = 16;
    localparam int MAG_BITS   = SCORE_BITS - 1;
    localparam int RANK_BITS  = 3;

    // one input request
    typedef struct packed {
        logic signed [SCORE_BITS-1:0] score;
        logic                         last_score;
    } score_item_t;

    // one result request
    typedef struct packed {
        logic [RANK_BITS-1:0]  rank;
        logic [INDEX_BITS-1:0] top_class;
        logic [MAG_BITS-1:0]   top_score;
        logic                  rank_found;
        logic                  last_rank;
    } result_item_t;

    // one list entry; a zero score marks an empty slot
    typedef struct packed {
        logic [MAG_BITS-1:0]   score;
        logic [INDEX_BITS-1:0] cls;
    } entry_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic                  en;
        logic                  clear;
        logic [MAG_BITS-1:0]   score;
        logic [INDEX_BITS-1:0] cls;
    } insert_t;

    localparam entry_t EMPTY_ENTRY = '{score: '0, cls: '1};

endpackage

`default_nettype wire

// ----- sv/tksel_cell.sv -----
// tksel_cell: one slot of the sorted list, shifts to its lower neighbor on insert
`default_nettype none

module tksel_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  tksel_pkg::insert_t ins,
    input  logic              prev_take,
    input  tksel_pkg::entry_t prev_entry,
    output logic              take,
    output tksel_pkg::entry_t upd,
    output tksel_pkg::entry_t entry
);

    tksel_pkg::entry_t entry_reg;
    tksel_pkg::entry_t entry_next;

    // new score beats this slot; ties keep the earlier class here
    assign take = ins.en && (ins.score > entry_reg.score);

    // updated content: neighbor moves down, or the new score lands here
    always_comb
    begin
        upd = entry_reg;
        if (prev_take)
        begin
            upd = prev_entry;
        end
        else if (take)
        begin
            upd.score = ins.score;
            upd.cls   = ins.cls;
        end
    end

    // clear after the marked score has been taken in
    assign entry_next = ins.clear ? tksel_pkg::EMPTY_ENTRY : upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= tksel_pkg::EMPTY_ENTRY;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ----- sv/tksel_out_queue.sv -----
// tksel_out_queue: snapshot of the list, drained one rank per request
`default_nettype none

module tksel_out_queue #(
    parameter int TOP_COUNT = tksel_pkg::TOP_COUNT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  tksel_pkg::entry_t        snap [TOP_COUNT],
    output logic                     can_load,
    output logic                     result_valid,
    input  logic                     result_stall,
    output tksel_pkg::result_item_t  result_data
);

    localparam int CNT_W  = $clog2(TOP_COUNT + 1);
    localparam int RANK_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

    tksel_pkg::entry_t  q_reg [TOP_COUNT];
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [RANK_W-1:0]  rank_reg;
    logic [RANK_W-1:0]  rank_next;
    logic               pop;
    logic               found;

    assign result_valid = (cnt_reg != '0);
    assign pop          = result_valid && !result_stall;
    assign can_load     = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && !result_stall);

    // count and rank bookkeeping
    always_comb
    begin
        cnt_next  = cnt_reg;
        rank_next = rank_reg;
        if (load)
        begin
            cnt_next  = CNT_W'(TOP_COUNT);
            rank_next = '0;
        end
        else if (pop)
        begin
            cnt_next  = cnt_reg - CNT_W'(1);
            rank_next = rank_reg + RANK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            rank_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            rank_reg <= rank_next;
        end
    end

    // snapshot load, else shift toward the head
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < TOP_COUNT; k++)
            begin
                q_reg[k] <= snap[k];
            end
        end
        else if (pop)
        begin
            for (int k = 0; k < TOP_COUNT - 1; k++)
            begin
                q_reg[k] <= q_reg[k + 1];
            end
        end
    end

    // head entry drives the result
    assign found = (q_reg[0].score != '0);

    always_comb
    begin
        result_data.rank       = tksel_pkg::RANK_BITS'(rank_reg);
        result_data.top_class  = found ? q_reg[0].cls : '1;
        result_data.top_score  = found ? q_reg[0].score : '0;
        result_data.rank_found = found;
        result_data.last_rank  = (rank_reg == RANK_W'(TOP_COUNT - 1));
    end

endmodule

`default_nettype wire

// ----- sv/top_k_score_select.sv -----
// top_k_score_select: streaming top-k selector built as a chain of list cells
//
//   channel   fields                    valid          stall
//   score     score, last_score         score_valid    score_stall
//   result    rank, top_class, ...      result_valid   result_stall
//
// one score request is taken per cycle unless stalled; the cells compare it
// with every slot in parallel and shift the list in the same cycle.
// results start the cycle after the marked score, one rank per unstalled cycle.
// a marked score stalls until the cycle in which the previous set's final result is taken.
// reset empties the list, the position count and the queue.
`default_nettype none

module top_k_score_select #(
    parameter int TOP_COUNT = tksel_pkg::TOP_COUNT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    score_valid,
    output logic                    score_stall,
    input  tksel_pkg::score_item_t  score_data,
    output logic                    result_valid,
    input  logic                    result_stall,
    output tksel_pkg::result_item_t result_data
);

    localparam int IB = tksel_pkg::INDEX_BITS;

    logic [IB:0]        pos_reg;
    logic [IB:0]        pos_next;
    logic               accept;
    logic               can_load;
    tksel_pkg::insert_t ins;
    logic               take [TOP_COUNT];
    tksel_pkg::entry_t  upd  [TOP_COUNT];
    tksel_pkg::entry_t  entry [TOP_COUNT];

    // marked score waits until the queue can take a snapshot
    assign score_stall = score_data.last_score && !can_load;
    assign accept      = score_valid && !score_stall;

    // request broadcast to the cells
    always_comb
    begin
        ins.en    = accept && !pos_reg[IB] && (score_data.score > 16'sd0);
        ins.clear = accept && score_data.last_score;
        ins.score = score_data.score[tksel_pkg::MAG_BITS-1:0];
        ins.cls   = pos_reg[IB-1:0];
    end

    // position count, saturating at the index range
    always_comb
    begin
        pos_next = pos_reg;
        if (ins.clear)
        begin
            pos_next = '0;
        end
        else if (accept && !pos_reg[IB])
        begin
            pos_next = pos_reg + (IB+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // chain of list cells
    for (genvar k = 0; k < TOP_COUNT; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            tksel_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ins        (ins),
                .prev_take  (1'b0),
                .prev_entry (tksel_pkg::EMPTY_ENTRY),
                .take       (take[k]),
                .upd        (upd[k]),
                .entry      (entry[k])
            );
        end
        else
        begin : g_body
            tksel_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ins        (ins),
                .prev_take  (take[k-1]),
                .prev_entry (entry[k-1]),
                .take       (take[k]),
                .upd        (upd[k]),
                .entry      (entry[k])
            );
        end
    end

    // result queue
    tksel_out_queue #(
        .TOP_COUNT (TOP_COUNT)
    ) u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (ins.clear),
        .snap         (upd),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

`default_nettype wire

// ----- sv/tksel_checker.sv -----
// tksel_checker: port-level assertions for the top-k selector, with its bind
`default_nettype none

module tksel_checker #(
    parameter int TOP_COUNT = tksel_pkg::TOP_COUNT
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    result_valid,
    input logic                    result_stall,
    input tksel_pkg::result_item_t result_data
);

    logic pop;
    assign pop = result_valid && !result_stall;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
        else $error("stalled result changed");

    // final rank is the last slot of the list
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.last_rank |->
            result_data.rank == tksel_pkg::RANK_BITS'(TOP_COUNT - 1))
        else $error("last_rank on wrong rank");

    // empty rank reads all ones and zero
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.rank_found |->
            (result_data.top_class == '1) && (result_data.top_score == '0))
        else $error("empty rank carries data");

    // ranks of a set follow back to back in order
    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !result_data.last_rank |=> result_valid &&
            (result_data.rank == tksel_pkg::RANK_BITS'($past(result_data.rank) + 3'd1)))
        else $error("rank sequence broken");

    // scores within a set never rise and empty ranks stay at the tail
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !result_data.last_rank |=>
            (!result_data.rank_found ||
             ($past(result_data.rank_found) &&
              (result_data.top_score <= $past(result_data.top_score)))))
        else $error("ranks out of order");

endmodule

bind top_k_score_select tksel_checker #(
    .TOP_COUNT (TOP_COUNT)
) u_tksel_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);

`default_nettype wire
